// ----- hdl/binary_bridging_3x3_defines.svh -----
// Assertion macros shared by the modules of the 3x3 binary bridging block.
`ifndef BINARY_BRIDGING_3X3_DEFINES_SVH
`define BINARY_BRIDGING_3X3_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bb3_pkg.sv -----
// Package of types and constants for the 3x3 binary bridging block.
`timescale 1ns / 1ps

package bb3_pkg;

	// Image geometry.
	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WIDTH_W      = 11;
	localparam int HEIGHT_W     = 13;
	localparam int ROW_W        = 13;
	localparam int PIX_W        = 8;
	localparam int CFG_DATA_W   = 13;
	localparam int REG_IDX_W    = 1;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [PIX_W-1:0] FILL_VALUE = 8'hFF;
	localparam logic [PIX_W-1:0] ZERO_PIXEL = 8'h00;

	// Queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Item codes.
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	// One classified slot of the stream, as queued for the back part.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pixel;
		logic             emit;
		logic             last;
		logic             bridge_en;
	} item_t;

	// Head of the queue as seen by the back part.
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

// ----- hdl/bb3_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bb3_front.sv -----
// Front part: configuration registers, frame counters and classification of each transaction.
`timescale 1ns / 1ps
`include "binary_bridging_3x3_defines.svh"

module bb3_front import bb3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [PIX_W-1:0]      in_pixel,
	input  logic                  q_full,
	output logic                  push,
	output item_t                 push_item
);

	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                in_frame;
	logic                row_end;
	logic                is_last;

	// Clamp the programmed geometry to the supported range.
	always_comb begin
		if (frame_width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (frame_width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else if (frame_height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = frame_height_q;
		end
	end

	// Classify the offered transaction against the slot position.
	always_comb begin
		in_frame = row_q < ROW_W'(h_eff);
		row_end  = (WIDTH_W'({1'b0, col_q}) + WIDTH_W'(1)) == w_eff;
		is_last  = (row_q == ROW_W'(h_eff + HEIGHT_W'(1))) && (col_q == '0);

		in_stall = q_full;
		push     = in_valid && !q_full && !(in_frame && (op == OP_FLUSH));

		push_item.col       = col_q;
		push_item.pixel     = in_frame ? in_pixel : ZERO_PIXEL;
		push_item.emit      = !((row_q == '0) || ((row_q == ROW_W'(1)) && (col_q == '0)));
		push_item.last      = is_last;
		push_item.bridge_en = (row_q >= ROW_W'(2)) && in_frame && (col_q >= COL_W'(2));
	end

	// Registers and frame counters; any register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[WIDTH_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[HEIGHT_W-1:0];
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (is_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	`BB3_ASSERT_NEXT(a_restart_after_last, push && push_item.last && !cfg_we,
		(col_q == '0) && (row_q == '0), "counters not cleared after the last pixel")

endmodule

// ----- hdl/bb3_fifo.sv -----
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
`include "binary_bridging_3x3_defines.svh"

module bb3_fifo import bb3_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Status and head of the queue.
	assign full       = count_q == QCNT_W'(QDEPTH);
	assign head.valid = count_q != '0;
	assign head.item  = mem_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`BB3_ASSERT_NOW(a_no_push_when_full, push, !full, "queue written while full")
	`BB3_ASSERT_NOW(a_no_pop_when_empty, pop, head.valid, "queue read while empty")
	`BB3_ASSERT_NEXT(a_count_tracks_push, push && !pop,
		count_q == $past(count_q) + QCNT_W'(1), "queue count lost a transaction")

endmodule

// ----- hdl/bb3_back.sv -----
// Back part: line stores, 3x3 window, bridging test and output register.
`timescale 1ns / 1ps
`include "binary_bridging_3x3_defines.svh"

module bb3_back import bb3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_head_t          head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] out_pixel,
	output logic             out_last
);

	logic             en;
	logic             wr_en;
	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] lower_rd;

	logic             valid_s1;
	item_t            item_s1;
	logic             valid_s2;
	item_t            item_s2;

	logic [PIX_W-1:0] win_q [3][3];
	logic [7:0]       nbits;
	logic [PIX_W-1:0] value;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;

	// Bridging conditions on the neighbour bits E, NE, N, NW, W, SW, S, SE (bit 0 upwards).
	function automatic logic bridge_fires(input logic [7:0] b);
		logic e, ne, n, nw, w, sw, s, se, diag_only, c1, c2, c3, c4, c5, c6;
		e  = b[0];
		ne = b[1];
		n  = b[2];
		nw = b[3];
		w  = b[4];
		sw = b[5];
		s  = b[6];
		se = b[7];
		diag_only = (b == 8'h0A) || (b == 8'h28) || (b == 8'hA0) || (b == 8'h82);
		c1 = !n && !s && (nw || w || sw) && (e || ne || se) && !diag_only;
		c2 = !e && !w && (ne || n || nw) && (sw || s || se) && !diag_only;
		c3 = !e && !s && se && (n || nw || w);
		c4 = !e && !n && ne && (w || sw || s);
		c5 = !n && !w && nw && (e || s || se);
		c6 = !w && !s && sw && (e || ne || n);
		return c1 || c2 || c3 || c4 || c5 || c6;
	endfunction

	// The whole back pipeline moves when the output register is free.
	assign en    = !out_valid_q || !out_stall;
	assign pop   = en && head.valid;
	assign wr_en = en && valid_s1;

	// Line stores: read at dequeue, written back as the item leaves stage one.
	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item_s1.col),
		.wdata (lower_rd),
		.re    (pop),
		.raddr (head.item.col),
		.rdata (upper_rd)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item_s1.col),
		.wdata (item_s1.pixel),
		.re    (pop),
		.raddr (head.item.col),
		.rdata (lower_rd)
	);

	// Pipeline valid flags and the output handshake register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= head.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && item_s2.emit;
		end
	end

	// Stage payloads; the window shifts in a new column only for a real item.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1     <= head.item;
			item_s2     <= item_s1;
			out_pixel_q <= value;
			out_last_q  <= item_s2.last;
			if (valid_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[0][2] <= upper_rd;
				win_q[1][2] <= lower_rd;
				win_q[2][2] <= item_s1.pixel;
			end
		end
	end

	// Bridging test on the centre of the window.
	always_comb begin
		nbits[0] = win_q[1][2] != ZERO_PIXEL;
		nbits[1] = win_q[0][2] != ZERO_PIXEL;
		nbits[2] = win_q[0][1] != ZERO_PIXEL;
		nbits[3] = win_q[0][0] != ZERO_PIXEL;
		nbits[4] = win_q[1][0] != ZERO_PIXEL;
		nbits[5] = win_q[2][0] != ZERO_PIXEL;
		nbits[6] = win_q[2][1] != ZERO_PIXEL;
		nbits[7] = win_q[2][2] != ZERO_PIXEL;
		value    = win_q[1][1];
		if (item_s2.bridge_en && (win_q[1][1] == ZERO_PIXEL) && bridge_fires(nbits)) begin
			value = FILL_VALUE;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

	`BB3_ASSERT_NOW(a_no_store_collision, pop && wr_en && !item_s1.last,
		head.item.col != item_s1.col, "line store read and written at one column")

endmodule

// ----- hdl/binary_bridging_3x3.sv -----
// Top level of the 3x3 binary bridging block: front part, queue and back part.
//
// Input channel (in_valid / in_stall): one transaction per slot of the raster,
// op = 0 with a pixel in in_pixel, op = 1 as a flush item. Flush items sent
// while pixels of the frame are still expected are taken and dropped; once the
// frame is in, every transaction acts as a zero pad. The source sends
// frame_width + 1 items after the last pixel to drain the frame.
// Output channel (out_valid / out_stall): one pixel per result, with out_last
// on the final pixel of the frame; the counters then restart for the next one.
// The result for a pixel is caused by the transaction frame_width + 1 slots
// later and leaves through the queue, stages one and two and the output register.
// Throughput is one transaction per cycle, set by the single read and write
// per line store and cycle. A four-entry queue parts front and back, so input
// is taken until it fills while out_stall holds the output register.
// Configuration (cfg_we, cfg_index, cfg_data) is written with the block idle;
// each write restarts the frame. Reset sets 640 x 480, clears counters, queue
// and pipeline flags; line stores are not cleared.
`timescale 1ns / 1ps

module binary_bridging_3x3 import bb3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [PIX_W-1:0]      in_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      out_pixel,
	output logic                  out_last
);

	logic    q_full;
	logic    push;
	item_t   push_item;
	logic    pop;
	q_head_t head;

	// Classification and frame counting.
	bb3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.in_pixel  (in_pixel),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Queue of classified transactions.
	bb3_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// Line stores, window and bridging.
	bb3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pixel (out_pixel),
		.out_last  (out_last)
	);

endmodule
